[design/tcps_pkg.sv]
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types and byte codes for the telnet com-port stream parser.
// ----------------------------------------------------------------------------
package tcps_pkg;

	localparam logic [7:0] CODE_IAC     = 8'd255;
	localparam logic [7:0] CODE_SB      = 8'd250;
	localparam logic [7:0] CODE_SE      = 8'd240;
	localparam logic [7:0] CODE_COMPORT = 8'd44;
	localparam logic [7:0] CODE_SETBAUD = 8'd1;

	localparam int RATE_BYTES = 4;
	localparam int CNT_W      = $clog2(RATE_BYTES);
	localparam int ACC_W      = 8 * (RATE_BYTES - 1);

	typedef enum logic [2:0] {
		ST_DATA   = 3'd0,
		ST_IAC    = 3'd1,
		ST_SB     = 3'd2,
		ST_OPT    = 3'd3,
		ST_RATE   = 3'd4,
		ST_WAITSE = 3'd5
	} parse_state_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_BAUD    = 1'b1
	} out_kind_t;

	typedef struct packed {
		logic        vld;
		out_kind_t   kind;
		logic [7:0]  payload;
		logic [31:0] baud;
	} result_t;

endpackage

[design/telnet_com_port_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// telnet_com_port_stream_parser_core
// Splits a telnet byte stream into serial payload bytes and baud-rate items.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_stall, in_byte[7:0]          | sink
//  out     | out_valid, out_stall, out_kind,           | source
//          | payload_byte[7:0], baud_rate[31:0]        |
//
// One item per cycle sustained while out_stall is low. An item is held in the
// input register and then decoded into the result register, which drives its
// result onto the output. Bytes that give no result are consumed without
// a bubble.
// in_stall rises only while both registers are full and out_stall is high.
// arst_n returns the parser to the data state with both registers empty.
// ----------------------------------------------------------------------------
module telnet_com_port_stream_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  payload_byte,
	output logic [31:0] baud_rate
);
	import tcps_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       step;
	logic       in_acc;
	result_t    res;

	assign step     = vld_s1 && free;
	assign in_stall = vld_s1 && !free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_acc)
			vld_s1 <= 1'b1;
		else if (step)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			byte_s1 <= in_byte;
	end

	tcps_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.res     (res)
	);

	tcps_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step),
		.res     (res),
		.stall   (out_stall),
		.free    (free),
		.valid   (out_valid),
		.kind    (out_kind),
		.payload (payload_byte),
		.baud    (baud_rate)
	);

endmodule

[design/tcps_parser.sv]
// ----------------------------------------------------------------------------
// tcps_parser
// Parse state, rate gathering and the decode of one byte into a result.
// ----------------------------------------------------------------------------
module tcps_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	output tcps_pkg::result_t res
);
	import tcps_pkg::*;

	parse_state_t     state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             last_rate;

	assign last_rate = (cnt_q == CNT_W'(RATE_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		unique case (state_q)
			ST_IAC: begin
				state_d = (byte_in == CODE_SB) ? ST_SB : ST_DATA;
			end
			ST_SB: begin
				if (byte_in == CODE_COMPORT) begin
					state_d = ST_OPT;
					cnt_d   = '0;
					acc_d   = '0;
				end else begin
					state_d = ST_DATA;
				end
			end
			ST_OPT: begin
				if (byte_in == CODE_SETBAUD)
					state_d = ST_RATE;
				else if (byte_in == CODE_IAC)
					state_d = ST_WAITSE;
			end
			ST_RATE: begin
				if (byte_in == CODE_IAC) begin
					state_d = ST_WAITSE;
				end else if (last_rate) begin
					state_d = ST_WAITSE;
					cnt_d   = '0;
					acc_d   = '0;
				end else begin
					acc_d = {acc_q[ACC_W-9:0], byte_in};
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_WAITSE: begin
				if (byte_in == CODE_SE)
					state_d = ST_DATA;
			end
			// data state and unused codes
			default: begin
				state_d = (byte_in == CODE_IAC) ? ST_IAC : ST_DATA;
			end
		endcase
	end

	// result
	always_comb begin
		res.vld     = 1'b0;
		res.kind    = KIND_PAYLOAD;
		res.payload = '0;
		res.baud    = '0;
		unique case (state_q)
			ST_IAC: begin
				if (byte_in == CODE_IAC) begin
					res.vld     = 1'b1;
					res.payload = byte_in;
				end
			end
			ST_SB, ST_OPT, ST_WAITSE: begin
				res.vld = 1'b0;
			end
			ST_RATE: begin
				if (byte_in != CODE_IAC && last_rate) begin
					res.vld  = 1'b1;
					res.kind = KIND_BAUD;
					res.baud = {acc_q, byte_in};
				end
			end
			default: begin
				if (byte_in != CODE_IAC) begin
					res.vld     = 1'b1;
					res.payload = byte_in;
				end
			end
		endcase
	end

endmodule

[design/tcps_out_stage.sv]
// ----------------------------------------------------------------------------
// tcps_out_stage
// Result register; holds an item while the receiver stalls.
// ----------------------------------------------------------------------------
module tcps_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tcps_pkg::result_t res,
	input  logic              stall,
	output logic              free,
	output logic              valid,
	output logic              kind,
	output logic [7:0]        payload,
	output logic [31:0]       baud
);
	import tcps_pkg::*;

	logic        vld_s2;
	out_kind_t   kind_s2;
	logic [7:0]  payload_s2;
	logic [31:0] baud_s2;

	assign free = !vld_s2 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (load)
			vld_s2 <= res.vld;
		else if (!stall)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load && res.vld) begin
			kind_s2    <= res.kind;
			payload_s2 <= res.payload;
			baud_s2    <= res.baud;
		end
	end

	assign valid   = vld_s2;
	assign kind    = kind_s2;
	assign payload = payload_s2;
	assign baud    = baud_s2;

endmodule

[design/tcps_checker.sv]
// ----------------------------------------------------------------------------
// tcps_checker
// Port-level checks for the stream parser, bound to the top level.
// ----------------------------------------------------------------------------
module tcps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        out_kind,
	input logic [7:0]  payload_byte,
	input logic [31:0] baud_rate
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_kind)
			&& $stable(payload_byte) && $stable(baud_rate))
		else $error("stalled output item changed");

	a_baud_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> payload_byte == 8'd0)
		else $error("baud item carries a payload byte");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> baud_rate == 32'd0)
		else $error("payload item carries a baud rate");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

endmodule

bind telnet_com_port_stream_parser_core tcps_checker u_tcps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_kind     (out_kind),
	.payload_byte (payload_byte),
	.baud_rate    (baud_rate)
);
